>>> rtl/zcre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zcre_pkg;

    localparam int unsigned MAX_BINS_DEF = 4096;
    localparam int unsigned SUM_W        = 44;
    localparam int unsigned CNT_W        = 32;
    localparam int unsigned STAMP_W      = 64;
    localparam int unsigned FRAC_W       = 30;   // log2 fraction bits
    localparam int unsigned EXP_W        = 6;    // floor(log2) of a 44-bit value
    localparam int unsigned LOG_W        = EXP_W + FRAC_W;
    localparam int unsigned MANT_W       = 32;   // Q1.31 mantissa
    localparam int unsigned QUO_W        = 63;   // floor(2^62 / x)
    localparam int unsigned SQ_W         = 64;
    localparam int unsigned OUT_W        = 32;
    localparam int unsigned ITER_W       = 6;

    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    localparam logic [ITER_W-1:0] LOG_LAST  = ITER_W'(FRAC_W - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(QUO_W - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQ_W / 2 - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_CHAN   = 2'd1,
        ST_ALL_FIRED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_T,
        S_LOG_T,
        S_SAVE_LT,
        S_NORM_E,
        S_LOG_E,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_E,
        S_SAVE_A,
        S_DIV_T,
        S_SQ_INIT,
        S_SQRT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    norm_load;
        logic    sel_emp;
        logic    norm_step;
        logic    log_init;
        logic    log_step;
        logic    save_lt;
        logic    save_d;
        logic    mul_lo;
        logic    mul_hi;
        logic    div_init;
        logic    div_step;
        logic    div_first;
        logic    save_a;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    emit;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_total;
        logic all_fired;
        logic norm_done;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/zero_counting_rate_estimator_core.sv
// Non-last bins: one per cycle while idle, busy stays low, no result.
// Last bin with no data: no result; with a zero valid sum or fired >= valid the
// status word appears on the strobe in the next cycle, still one bin per cycle.
// Otherwise busy through two normalize loops, two 30-step log squarings, two
// dividers for 63-bit quotients and a square root; strobe in first idle cycle.
// Async active-low reset clears sums, bin count and controller; no reset pass.
`timescale 1ns / 1ps
`default_nettype none

module zero_counting_rate_estimator_core
    import zcre_pkg::*;
#(
    parameter int unsigned MAX_BINS = MAX_BINS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [CNT_W-1:0]   fired_count,
    input  wire logic [CNT_W-1:0]   valid_count,
    input  wire logic               has_data,
    input  wire logic [STAMP_W-1:0] time_start,
    input  wire logic [STAMP_W-1:0] time_end,
    input  wire logic               last_bin,
    output logic                    strobe,
    output logic [1:0]              status,
    output logic [OUT_W-1:0]        rate_estimate,
    output logic [OUT_W-1:0]        rate_error,
    output logic [STAMP_W-1:0]      stamp_start,
    output logic [STAMP_W-1:0]      stamp_end
);

    // controller sequences the shared log and divide units and the root unit
    dp_cmd_t  cmd;
    dp_stat_t stat;

    zcre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .has_data (has_data),
        .last_bin (last_bin),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // datapath: saturating sums, log2 squarer, divider, root, result word
    zcre_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .fired_count   (fired_count),
        .valid_count   (valid_count),
        .time_start    (time_start),
        .time_end      (time_end),
        .last_bin      (last_bin),
        .stat          (stat),
        .strobe        (strobe),
        .status        (status),
        .rate_estimate (rate_estimate),
        .rate_error    (rate_error),
        .stamp_start   (stamp_start),
        .stamp_end     (stamp_end)
    );

endmodule

`default_nettype wire

>>> rtl/zcre_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module zcre_ctrl
    import zcre_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     has_data,
    input  wire logic     last_bin,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy
);

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && last_bin && has_data && !stat.zero_total && !stat.all_fired)
                    state_next = S_NORM_T;
            end
            S_NORM_T:  if (stat.norm_done) state_next = S_LOG_T;
            S_LOG_T:   if (cnt_reg == LOG_LAST) state_next = S_SAVE_LT;
            S_SAVE_LT: state_next = S_NORM_E;
            S_NORM_E:  if (stat.norm_done) state_next = S_LOG_E;
            S_LOG_E:   if (cnt_reg == LOG_LAST) state_next = S_DIFF;
            S_DIFF:    state_next = S_MUL_LO;
            S_MUL_LO:  state_next = S_MUL_HI;
            S_MUL_HI:  state_next = S_DIV_E;
            S_DIV_E:   if (cnt_reg == DIV_LAST) state_next = S_SAVE_A;
            S_SAVE_A:  state_next = S_DIV_T;
            S_DIV_T:   if (cnt_reg == DIV_LAST) state_next = S_SQ_INIT;
            S_SQ_INIT: state_next = S_SQRT;
            S_SQRT:    if (cnt_reg == SQRT_LAST) state_next = S_EMIT;
            S_EMIT:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        cmd.code = ST_OK;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = start;
                if (start && last_bin && has_data)
                begin
                    priority if (stat.zero_total)
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = ST_NO_CHAN;
                    end
                    else if (stat.all_fired)
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = ST_ALL_FIRED;
                    end
                    else
                        cmd.norm_load = 1'b1;
                end
            end
            S_NORM_T, S_NORM_E:
            begin
                if (stat.norm_done) cmd.log_init = 1'b1;
                else                cmd.norm_step = 1'b1;
            end
            S_LOG_T, S_LOG_E: cmd.log_step = 1'b1;
            S_SAVE_LT:
            begin
                cmd.save_lt   = 1'b1;
                cmd.norm_load = 1'b1;
                cmd.sel_emp   = 1'b1;
            end
            S_DIFF:   cmd.save_d = 1'b1;
            S_MUL_LO: cmd.mul_lo = 1'b1;
            S_MUL_HI:
            begin
                cmd.mul_hi   = 1'b1;
                cmd.div_init = 1'b1;
                cmd.sel_emp  = 1'b1;
            end
            S_DIV_E, S_DIV_T:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
            end
            S_SAVE_A:
            begin
                cmd.save_a   = 1'b1;
                cmd.div_init = 1'b1;
            end
            S_SQ_INIT: cmd.sqrt_init = 1'b1;
            S_SQRT:    cmd.sqrt_step = 1'b1;
            S_EMIT:    cmd.emit = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/zcre_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module zcre_dp
    import zcre_pkg::*;
#(
    parameter int unsigned MAX_BINS = MAX_BINS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire logic [CNT_W-1:0]   fired_count,
    input  wire logic [CNT_W-1:0]   valid_count,
    input  wire logic [STAMP_W-1:0] time_start,
    input  wire logic [STAMP_W-1:0] time_end,
    input  wire logic               last_bin,
    output dp_stat_t                stat,
    output logic                    strobe,
    output logic [1:0]              status,
    output logic [OUT_W-1:0]        rate_estimate,
    output logic [OUT_W-1:0]        rate_error,
    output logic [STAMP_W-1:0]      stamp_start,
    output logic [STAMP_W-1:0]      stamp_end
);

    localparam int unsigned BIN_W = $clog2(MAX_BINS + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // accumulation
    logic [SUM_W-1:0] fired_sum_reg, valid_sum_reg;
    logic [SUM_W-1:0] fired_upd, valid_upd;
    logic [SUM_W:0]   fired_add, valid_add;
    logic [BIN_W-1:0] bin_cnt_reg;
    logic             room;

    assign room      = (bin_cnt_reg < BIN_W'(MAX_BINS));
    assign fired_add = {1'b0, fired_sum_reg} + (SUM_W+1)'(fired_count);
    assign valid_add = {1'b0, valid_sum_reg} + (SUM_W+1)'(valid_count);
    assign fired_upd = !room ? fired_sum_reg : (fired_add[SUM_W] ? SUM_MAX : fired_add[SUM_W-1:0]);
    assign valid_upd = !room ? valid_sum_reg : (valid_add[SUM_W] ? SUM_MAX : valid_add[SUM_W-1:0]);

    assign stat.zero_total = (valid_upd == '0);
    assign stat.all_fired  = (fired_upd >= valid_upd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fired_sum_reg <= '0;
            valid_sum_reg <= '0;
            bin_cnt_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_bin)
            begin
                fired_sum_reg <= '0;
                valid_sum_reg <= '0;
                bin_cnt_reg   <= '0;
            end
            else
            begin
                fired_sum_reg <= fired_upd;
                valid_sum_reg <= valid_upd;
                if (room) bin_cnt_reg <= bin_cnt_reg + 1'b1;
            end
        end
    end

    // totals of the closed histogram
    logic [SUM_W-1:0] tot_reg, emp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_bin)
        begin
            tot_reg <= valid_upd;
            emp_reg <= valid_upd - fired_upd;
        end
    end

    // log2: normalize one bit a cycle, then 30 squarings
    logic [SUM_W-1:0]    x_reg;
    logic [EXP_W-1:0]    k_reg;
    logic [MANT_W-1:0]   m_reg;
    logic [FRAC_W-1:0]   f_reg;
    logic [LOG_W-1:0]    lt_reg, d_reg, le;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_sh;

    assign stat.norm_done = x_reg[SUM_W-1];
    assign sq    = m_reg * m_reg;
    assign sq_sh = sq[2*MANT_W-1:MANT_W-1];
    assign le    = {k_reg, f_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.norm_load)
        begin
            x_reg <= cmd.sel_emp ? emp_reg : valid_upd;
            k_reg <= EXP_W'(SUM_W - 1);
        end
        else if (cmd.norm_step)
        begin
            x_reg <= {x_reg[SUM_W-2:0], 1'b0};
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.log_init)
        begin
            m_reg <= x_reg[SUM_W-1 -: MANT_W];
            f_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            m_reg <= sq_sh[MANT_W] ? sq_sh[MANT_W:1] : sq_sh[MANT_W-1:0];
            f_reg <= {f_reg[FRAC_W-2:0], sq_sh[MANT_W]};
        end
        if (cmd.save_lt) lt_reg <= le;
        if (cmd.save_d)  d_reg  <= (lt_reg > le) ? lt_reg - le : '0;
    end

    // rate = (D * ln2 + 2^30) >> 31, two partial products on 18-bit halves of D
    localparam int unsigned HALF = LOG_W / 2;
    logic [HALF+27:0]  prod_reg;
    logic [HALF+27:0]  prod_hi;
    logic [64:0]       rate_sum;
    logic [33:0]       rate_full;
    logic [OUT_W-1:0]  rate_reg;

    assign prod_hi   = d_reg[LOG_W-1:HALF] * LN2_Q28;
    assign rate_sum  = 65'(prod_reg) + (65'(prod_hi) << HALF) + (65'd1 << 30);
    assign rate_full = rate_sum[64:31];

    // restoring divider for 2^62 / x
    logic [SUM_W-1:0] dvs_reg, rem_reg;
    logic [SUM_W:0]   r2;
    logic             ge;
    logic [QUO_W-1:0] q_reg, a_reg;
    logic [SQ_W-1:0]  v_reg, res_reg, bit_reg, trial;
    logic [OUT_W-1:0] err_reg;
    status_t          status_reg;
    logic             strobe_reg;

    assign r2    = {rem_reg, cmd.div_first};
    assign ge    = (r2 >= {1'b0, dvs_reg});
    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo) prod_reg <= d_reg[HALF-1:0] * LN2_Q28;
        if (cmd.mul_hi) rate_reg <= (|rate_full[33:32]) ? '1 : rate_full[31:0];
        if (cmd.emit && cmd.code != ST_OK) rate_reg <= '0;

        if (cmd.div_init)
        begin
            dvs_reg <= cmd.sel_emp ? emp_reg : tot_reg;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? SUM_W'(r2 - {1'b0, dvs_reg}) : r2[SUM_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
        if (cmd.save_a) a_reg <= q_reg;

        if (cmd.sqrt_init)
        begin
            v_reg   <= {SQ_W'(a_reg - q_reg)} << 2;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            err_reg    <= (cmd.code == ST_OK) ? res_reg[OUT_W-1:0] : '0;
        end
        if (cmd.accept && last_bin)
        begin
            stamp_start <= time_start;
            stamp_end   <= time_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) strobe_reg <= 1'b0;
        else        strobe_reg <= cmd.emit;
    end

    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign rate_estimate = rate_reg;
    assign rate_error    = err_reg;

endmodule

`default_nettype wire

>>> rtl/zcre_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module zcre_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        has_data,
    input wire logic        last_bin,
    input wire logic        strobe,
    input wire logic [1:0]  status,
    input wire logic [31:0] rate_estimate,
    input wire logic [31:0] rate_error
);

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy) else $error("result word while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (status != 2'd3)) else $error("undefined status");

    a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != 2'd0) |-> (rate_estimate == '0 && rate_error == '0))
        else $error("nonzero estimate with fault status");

    a_no_result_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (!last_bin || !has_data)) |=> !strobe)
        else $error("result without a closing bin");

endmodule

bind zero_counting_rate_estimator_core zcre_checker u_zcre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .has_data      (has_data),
    .last_bin      (last_bin),
    .strobe        (strobe),
    .status        (status),
    .rate_estimate (rate_estimate),
    .rate_error    (rate_error)
);

`default_nettype wire
